// ===== rtl/vtpd_pkg.sv =====
// Shared types and constants for the vertex transform and perspective divide block.
`timescale 1ns / 1ps
package vtpd_pkg;

   localparam int QUOT_BITS = 32;
   localparam int NUM_REGS  = 8;
   localparam int REG_BITS  = 64;

   localparam logic [REG_BITS-1:0] REG_RESET [NUM_REGS] = '{
      64'd4294967296, 64'd0, 64'd65536, 64'd0,
      64'd0, 64'd4294967296, 64'd0, 64'd65536
   };

   typedef struct packed {
      logic                        valid;
      logic                        op;
      logic                        near;
      logic [2:0]                  neg;
      logic [2:0]                  ovf;
      logic [2:0][QUOT_BITS-1:0]   clamped;
      logic                        csat;
   } side_type;

endpackage

// ===== rtl/vtpd_div_lane.sv =====
// Pipelined restoring divider lane giving one quotient bit per stage.
`timescale 1ns / 1ps
module vtpd_div_lane #(
   parameter int FRAC_BITS = 16,
   parameter int TW        = 50
) (
   input  logic                                clock,
   input  logic                                en,
   input  logic [TW-1:0]                       num,
   input  logic [TW-1:0]                       den,
   output logic [vtpd_pkg::QUOT_BITS-1:0]      quot
);
   import vtpd_pkg::*;

   localparam int DW = TW + QUOT_BITS;

   logic [DW-1:0]        rem_ff  [0:QUOT_BITS];
   logic [TW-1:0]        den_ff  [0:QUOT_BITS];
   logic [QUOT_BITS-1:0] quot_ff [0:QUOT_BITS];

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= DW'(num) << FRAC_BITS;
         den_ff[0]  <= den;
         quot_ff[0] <= '0;
      end
   end

   for (genvar k = 0; k < QUOT_BITS; k++) begin : g_step
      logic [DW-1:0] dsh;
      logic [DW:0]   diff;
      assign dsh  = DW'(den_ff[k]) << (QUOT_BITS - 1 - k);
      assign diff = {1'b0, rem_ff[k]} - {1'b0, dsh};
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1]  <= diff[DW] ? rem_ff[k] : diff[DW-1:0];
            den_ff[k+1]  <= den_ff[k];
            quot_ff[k+1] <= {quot_ff[k][QUOT_BITS-2:0], ~diff[DW]};
         end
      end
   end

   assign quot = quot_ff[QUOT_BITS];

endmodule

// ===== rtl/vertex_transform_persp_divide.sv =====
// Top level: 4x4 homogeneous vertex transform with optional perspective divide.
//
//  Channel | Ports          | Content
//  --------+----------------+----------------------------------------------
//  req     | req_t*         | tdata: in_x, in_y, in_z, in_w; tuser: op
//  rsp     | rsp_t*         | tdata: out_x, out_y, out_z; tuser: w_near_zero, saturated
//  csr     | csr_*          | matrix register writes, two entries per register
//
// One word is taken every cycle unless rsp stalls; the 32-step divider dominates latency.
// Reset clears all valid bits and loads a diagonal matrix of raw 1, 65536, 1, 65536.
// A stall on rsp freezes the whole pipeline, so no word is lost or repeated.
`timescale 1ns / 1ps
module vertex_transform_persp_divide #(
   parameter int FRAC_BITS         = 16,
   parameter int NEAR_ZERO_EPSILON = 7
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,  // in_x, in_y, in_z, in_w
   input  logic         req_tuser,  // op
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [95:0]  rsp_tdata,  // out_x, out_y, out_z
   output logic [1:0]   rsp_tuser,  // w_near_zero, saturated
   input  logic         csr_wr,
   input  logic [2:0]   csr_addr,
   input  logic [63:0]  csr_wdata
);
   import vtpd_pkg::*;

   localparam int PW = 66;
   localparam int TW = PW - FRAC_BITS;

   logic en;
   logic [REG_BITS-1:0] mat_ff [NUM_REGS];

   logic              v0_ff, op0_ff;
   logic signed [31:0] p0_ff [4];
   logic              v1_ff, op1_ff;
   logic signed [63:0] prod1_ff [4][4];
   logic              v2_ff, op2_ff;
   logic signed [TW-1:0] t2_ff [4];
   logic              v3_ff, op3_ff, near3_ff, csat3_ff;
   logic [2:0]        neg3_ff;
   logic [TW-1:0]     n3_ff [3];
   logic [TW-1:0]     d3_ff;
   logic [2:0][31:0]  cl3_ff;
   side_type          sb_ff [0:QUOT_BITS];
   side_type          sb_in;
   logic [31:0]       quot [3];
   logic              out_valid_ff;
   logic [95:0]       out_data_ff, out_data_in;
   logic [1:0]        out_user_ff, out_user_in;

   assign en         = !out_valid_ff || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) mat_ff[i] <= REG_RESET[i];
      end else if (csr_wr) begin
         mat_ff[csr_addr] <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= req_tvalid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         op0_ff <= req_tuser;
         for (int r = 0; r < 4; r++) p0_ff[r] <= req_tdata[32*r +: 32];
      end
   end

   always_ff @(posedge clock) begin
      logic signed [31:0] m;
      if (en) begin
         op1_ff <= op0_ff;
         for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
               m = (c % 2 == 0) ? mat_ff[r*2 + c/2][63:32] : mat_ff[r*2 + c/2][31:0];
               prod1_ff[r][c] <= p0_ff[r] * m;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      logic signed [PW-1:0] s;
      if (en) begin
         op2_ff <= op1_ff;
         for (int c = 0; c < 4; c++) begin
            s = PW'(prod1_ff[0][c]) + PW'(prod1_ff[1][c])
              + PW'(prod1_ff[2][c]) + PW'(prod1_ff[3][c]);
            t2_ff[c] <= s[PW-1:FRAC_BITS];
         end
      end
   end

   always_ff @(posedge clock) begin
      logic signed [TW-1:0] eps;
      logic csat;
      if (en) begin
         eps  = TW'(NEAR_ZERO_EPSILON);
         csat = 1'b0;
         op3_ff   <= op2_ff;
         near3_ff <= (t2_ff[3] >= -eps) && (t2_ff[3] <= eps);
         d3_ff    <= t2_ff[3][TW-1] ? TW'(-t2_ff[3]) : TW'(t2_ff[3]);
         for (int c = 0; c < 3; c++) begin
            neg3_ff[c] <= t2_ff[c][TW-1] ^ t2_ff[3][TW-1];
            n3_ff[c]   <= t2_ff[c][TW-1] ? TW'(-t2_ff[c]) : TW'(t2_ff[c]);
            if (t2_ff[c] > TW'(signed'(32'sh7fffffff))) begin
               cl3_ff[c] <= 32'h7fffffff;
               csat = 1'b1;
            end else if (t2_ff[c] < TW'(signed'(32'sh80000000))) begin
               cl3_ff[c] <= 32'h80000000;
               csat = 1'b1;
            end else begin
               cl3_ff[c] <= t2_ff[c][31:0];
            end
         end
         csat3_ff <= csat;
      end
   end

   always_comb begin
      sb_in.valid   = v3_ff;
      sb_in.op      = op3_ff;
      sb_in.near    = near3_ff;
      sb_in.neg     = neg3_ff;
      sb_in.clamped = cl3_ff;
      sb_in.csat    = csat3_ff;
      for (int c = 0; c < 3; c++) begin
         sb_in.ovf[c] = (TW+32)'(n3_ff[c]) >= ((TW+32)'(d3_ff) << (32 - FRAC_BITS));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= QUOT_BITS; k++) sb_ff[k] <= '0;
      end else if (en) begin
         sb_ff[0] <= sb_in;
         for (int k = 0; k < QUOT_BITS; k++) sb_ff[k+1] <= sb_ff[k];
      end
   end

   for (genvar c = 0; c < 3; c++) begin : g_lane
      vtpd_div_lane #(
         .FRAC_BITS (FRAC_BITS),
         .TW        (TW)
      ) u_lane (
         .clock (clock),
         .en    (en),
         .num   (n3_ff[c]),
         .den   (d3_ff),
         .quot  (quot[c])
      );
   end

   always_comb begin
      side_type sb;
      logic sat;
      sb  = sb_ff[QUOT_BITS];
      sat = 1'b0;
      out_data_in = '0;
      if (sb.op && !sb.near) begin
         for (int c = 0; c < 3; c++) begin
            if (sb.ovf[c]) begin
               sat = 1'b1;
               out_data_in[32*c +: 32] = sb.neg[c] ? 32'h80000000 : 32'h7fffffff;
            end else if (sb.neg[c]) begin
               if (quot[c] > 32'h80000000) begin
                  sat = 1'b1;
                  out_data_in[32*c +: 32] = 32'h80000000;
               end else begin
                  out_data_in[32*c +: 32] = -quot[c];
               end
            end else if (quot[c] > 32'h7fffffff) begin
               sat = 1'b1;
               out_data_in[32*c +: 32] = 32'h7fffffff;
            end else begin
               out_data_in[32*c +: 32] = quot[c];
            end
         end
      end else begin
         for (int c = 0; c < 3; c++) out_data_in[32*c +: 32] = sb.clamped[c];
         sat = sb.csat;
      end
      out_user_in = {sat, sb.op && sb.near};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= sb_ff[QUOT_BITS].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_data_ff <= out_data_in;
         out_user_ff <= out_user_in;
      end
   end

endmodule
